@@ rtl/aeg_pkg.sv @@
`default_nettype none

package aeg_pkg;

  localparam int SAMPLES_PER_MS = 48;

  localparam int MS_W      = 16;
  localparam int SAMPLE_W  = 16;
  localparam int SUS_W     = 8;
  localparam int STAGE_W   = 3;
  localparam int ELAPSED_W = 22;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int LEN_W  = $clog2(SAMPLES_PER_MS * ((1 << MS_W) - 1) + 1);
  localparam int WIDE_W = (LEN_W > ELAPSED_W) ? LEN_W : ELAPSED_W;
  localparam int DEN_W  = LEN_W + SUS_W;
  localparam int GAIN_W = SAMPLE_W + 1;
  localparam int PROD_W = SAMPLE_W + GAIN_W;

  localparam int SUS_FULL = (1 << SUS_W) - 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  localparam logic [STAGE_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
  localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd2;
  localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd3;
  localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [STAGE_W-1:0]         stage;
    logic [ELAPSED_W-1:0]       count;
    logic [LEN_W-1:0]           len;
  } item_t;

  function automatic logic [LEN_W-1:0] stage_len(input logic [MS_W-1:0] ms);
    logic [LEN_W-1:0] p;
    p = LEN_W'(ms) * LEN_W'(SAMPLES_PER_MS);
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/adsr_envelope_gain.sv @@
// Linear ADSR envelope gain on a stream of signed 16-bit samples.
// Input channel (in_valid/in_ready): one sample per transfer, optionally
// with a gate write that restarts the envelope in attack (level 1) or
// release (level 0) before the sample is scaled.
// Output channel (out_valid/out_ready): the scaled sample, truncated toward
// zero, and the stage code that formed its gain.
// Configuration: cfg_we/cfg_index/cfg_data write attack, decay, sustain
// and release settings; write only while no transfer is
// in flight.
// The front end updates the envelope state in the cycle of the transfer
// and queues the work (two entries). The back end works on one sample at a
// time and takes the next only when done: a restoring divider yields one
// gain bit per cycle, then the product is registered and the result goes to
// the output register.
// When out_ready is low the result holds in the output register, the back
// end waits, and in_ready drops once the queue is full.
// Synchronous reset returns the envelope to idle, the settings to zero
// lengths with full sustain, and empties the queue and output register.
`default_nettype none

module adsr_envelope_gain (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [aeg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [aeg_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_gate_write,
  input  wire logic                                in_gate_level,
  input  wire logic signed [aeg_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [aeg_pkg::SAMPLE_W-1:0]      out_sample,
  output logic [aeg_pkg::STAGE_W-1:0]              out_stage
);

  aeg_pkg::item_t               q_wdata;
  aeg_pkg::item_t               q_rdata;
  logic                         q_push;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_empty;
  logic [aeg_pkg::SUS_W-1:0]    sustain_level;

  aeg_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_gate_write (in_gate_write),
    .in_gate_level (in_gate_level),
    .in_sample     (in_sample),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata),
    .sustain_level (sustain_level)
  );

  aeg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  aeg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .sustain_level (sustain_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample),
    .out_stage     (out_stage)
  );

`ifndef ASSERT_OFF
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_stage == aeg_pkg::ST_IDLE) |-> (out_sample == '0))
    else $error("idle stage produced a nonzero sample");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end took work from an empty queue");

  a_release_after_gate: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && in_gate_write && !in_gate_level |-> (q_wdata.stage == aeg_pkg::ST_RELEASE))
    else $error("gate low did not enter release");
`endif

endmodule

`default_nettype wire

@@ rtl/aeg_queue.sv @@
`default_nettype none

module aeg_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire aeg_pkg::item_t wdata,
  input  wire logic          pop,
  output aeg_pkg::item_t     rdata,
  output logic               full,
  output logic               empty
);

  aeg_pkg::item_t                  mem_r [aeg_pkg::QUEUE_DEPTH];
  logic [aeg_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [aeg_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [aeg_pkg::QCNT_W-1:0]      cnt_r;
  logic [aeg_pkg::QPTR_W-1:0]      wr_ptr_nxt;
  logic [aeg_pkg::QPTR_W-1:0]      rd_ptr_nxt;

  assign full  = (cnt_r == aeg_pkg::QCNT_W'(aeg_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == aeg_pkg::QPTR_W'(aeg_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : wr_ptr_r + aeg_pkg::QPTR_W'(1);
  assign rd_ptr_nxt = (rd_ptr_r == aeg_pkg::QPTR_W'(aeg_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : rd_ptr_r + aeg_pkg::QPTR_W'(1);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + aeg_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - aeg_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/aeg_front.sv @@
`default_nettype none

module aeg_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [aeg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [aeg_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_gate_write,
  input  wire logic                              in_gate_level,
  input  wire logic signed [aeg_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output aeg_pkg::item_t                         q_wdata,
  output logic [aeg_pkg::SUS_W-1:0]              sustain_level
);

  logic [aeg_pkg::MS_W-1:0]      attack_ms_r;
  logic [aeg_pkg::MS_W-1:0]      decay_ms_r;
  logic [aeg_pkg::SUS_W-1:0]     sustain_level_r;
  logic [aeg_pkg::MS_W-1:0]      release_ms_r;
  logic [aeg_pkg::STAGE_W-1:0]   stage_r;
  logic [aeg_pkg::ELAPSED_W-1:0] elapsed_r;
  logic [aeg_pkg::STAGE_W-1:0]   stage_nxt;
  logic [aeg_pkg::ELAPSED_W-1:0] elapsed_nxt;

  logic [aeg_pkg::STAGE_W-1:0]   st_g;
  logic [aeg_pkg::ELAPSED_W-1:0] el_g;
  logic [aeg_pkg::ELAPSED_W-1:0] el_t;
  logic [aeg_pkg::ELAPSED_W-1:0] c_used;
  logic [aeg_pkg::LEN_W-1:0]     len_g;
  logic [aeg_pkg::WIDE_W-1:0]    len_w;
  logic                          timed_out;

  assign in_ready      = !q_full;
  assign q_push        = in_valid && !q_full;
  assign sustain_level = sustain_level_r;

  always_comb begin
    st_g = stage_r;
    el_g = elapsed_r;
    if (in_gate_write) begin
      st_g = in_gate_level ? aeg_pkg::ST_ATTACK : aeg_pkg::ST_RELEASE;
      el_g = '0;
    end
    case (st_g)
      aeg_pkg::ST_ATTACK:  len_g = aeg_pkg::stage_len(attack_ms_r);
      aeg_pkg::ST_DECAY:   len_g = aeg_pkg::stage_len(decay_ms_r);
      aeg_pkg::ST_RELEASE: len_g = aeg_pkg::stage_len(release_ms_r);
      default:             len_g = '0;
    endcase
    len_w  = aeg_pkg::WIDE_W'(len_g);
    c_used = (aeg_pkg::WIDE_W'(el_g) > len_w) ? aeg_pkg::ELAPSED_W'(len_w) : el_g;
    el_t   = (el_g == aeg_pkg::ELAPSED_MAX) ? el_g : el_g + aeg_pkg::ELAPSED_W'(1);
    timed_out = aeg_pkg::WIDE_W'(el_t) > len_w;
  end

  always_comb begin
    q_wdata.sample = in_sample;
    q_wdata.stage  = st_g;
    q_wdata.count  = c_used;
    q_wdata.len    = len_g;
  end

  always_comb begin
    stage_nxt   = stage_r;
    elapsed_nxt = elapsed_r;
    if (q_push) begin
      stage_nxt   = st_g;
      elapsed_nxt = el_t;
      case (st_g)
        aeg_pkg::ST_ATTACK: begin
          if (timed_out) begin
            stage_nxt   = aeg_pkg::ST_DECAY;
            elapsed_nxt = '0;
          end
        end
        aeg_pkg::ST_DECAY: begin
          if (timed_out) begin
            stage_nxt = aeg_pkg::ST_SUSTAIN;
          end
        end
        aeg_pkg::ST_RELEASE: begin
          if (timed_out) begin
            stage_nxt = aeg_pkg::ST_IDLE;
          end
        end
        default: begin
          stage_nxt = st_g;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_ms_r     <= '0;
      decay_ms_r      <= '0;
      sustain_level_r <= aeg_pkg::SUS_W'(aeg_pkg::SUS_FULL);
      release_ms_r    <= '0;
      stage_r         <= aeg_pkg::ST_IDLE;
      elapsed_r       <= '0;
    end else begin
      stage_r   <= stage_nxt;
      elapsed_r <= elapsed_nxt;
      if (cfg_we) begin
        case (cfg_index)
          aeg_pkg::CFG_ATTACK:  attack_ms_r     <= cfg_data;
          aeg_pkg::CFG_DECAY:   decay_ms_r      <= cfg_data;
          aeg_pkg::CFG_SUSTAIN: sustain_level_r <= cfg_data[aeg_pkg::SUS_W-1:0];
          aeg_pkg::CFG_RELEASE: release_ms_r    <= cfg_data;
          default:              release_ms_r    <= release_ms_r;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/aeg_back.sv @@
`default_nettype none

module aeg_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire aeg_pkg::item_t                    head,
  input  wire logic                              q_empty,
  output logic                                   q_pop,
  input  wire logic [aeg_pkg::SUS_W-1:0]         sustain_level,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [aeg_pkg::SAMPLE_W-1:0]    out_sample,
  output logic [aeg_pkg::STAGE_W-1:0]            out_stage
);

  localparam int CNT_W = $clog2(aeg_pkg::GAIN_W);

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_DONE
  } bstate_t;

  bstate_t                          state_r;
  logic [aeg_pkg::DEN_W:0]          rem_r;
  logic [aeg_pkg::DEN_W-1:0]        den_r;
  logic [aeg_pkg::GAIN_W-1:0]       gain_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [aeg_pkg::SAMPLE_W-1:0]     mag_r;
  logic                             neg_r;
  logic [aeg_pkg::STAGE_W-1:0]      stage_r;
  logic [aeg_pkg::PROD_W-1:0]       prod_r;
  logic                             out_valid_r;
  logic signed [aeg_pkg::SAMPLE_W-1:0] out_sample_r;
  logic [aeg_pkg::STAGE_W-1:0]      out_stage_r;

  logic [aeg_pkg::LEN_W-1:0]        len_m_c;
  logic [aeg_pkg::DEN_W-1:0]        den255;
  logic [aeg_pkg::SUS_W-1:0]        mul_a;
  logic [aeg_pkg::LEN_W-1:0]        mul_b;
  logic [aeg_pkg::DEN_W-1:0]        mul_p;
  logic [aeg_pkg::DEN_W-1:0]        num_pre;
  logic [aeg_pkg::DEN_W-1:0]        den_pre;
  logic [aeg_pkg::SAMPLE_W-1:0]     mag_pre;
  logic                             len_zero;

  logic                             ge;
  logic [aeg_pkg::DEN_W:0]          diff;
  logic [aeg_pkg::DEN_W:0]          rem_shift;

  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_stage  = out_stage_r;

  always_comb begin
    len_zero = (head.len == '0);
    len_m_c  = aeg_pkg::LEN_W'(aeg_pkg::WIDE_W'(head.len) - aeg_pkg::WIDE_W'(head.count));
    den255   = (aeg_pkg::DEN_W'(head.len) << aeg_pkg::SUS_W) - aeg_pkg::DEN_W'(head.len);
    if (head.stage == aeg_pkg::ST_DECAY) begin
      mul_a = aeg_pkg::SUS_W'(aeg_pkg::SUS_FULL) - sustain_level;
      mul_b = aeg_pkg::LEN_W'(head.count);
    end else begin
      mul_a = sustain_level;
      mul_b = len_m_c;
    end
    mul_p = aeg_pkg::DEN_W'(mul_a) * aeg_pkg::DEN_W'(mul_b);

    num_pre = '0;
    den_pre = aeg_pkg::DEN_W'(1);
    case (head.stage)
      aeg_pkg::ST_ATTACK: begin
        if (len_zero) begin
          num_pre = aeg_pkg::DEN_W'(1);
        end else begin
          num_pre = aeg_pkg::DEN_W'(head.count);
          den_pre = aeg_pkg::DEN_W'(head.len);
        end
      end
      aeg_pkg::ST_DECAY: begin
        if (len_zero) begin
          num_pre = aeg_pkg::DEN_W'(sustain_level);
          den_pre = aeg_pkg::DEN_W'(aeg_pkg::SUS_FULL);
        end else begin
          num_pre = den255 - mul_p;
          den_pre = den255;
        end
      end
      aeg_pkg::ST_SUSTAIN: begin
        num_pre = aeg_pkg::DEN_W'(sustain_level);
        den_pre = aeg_pkg::DEN_W'(aeg_pkg::SUS_FULL);
      end
      aeg_pkg::ST_RELEASE: begin
        if (!len_zero) begin
          num_pre = mul_p;
          den_pre = den255;
        end
      end
      default: begin
        num_pre = '0;
      end
    endcase

    mag_pre = head.sample[aeg_pkg::SAMPLE_W-1] ?
              (~head.sample) + aeg_pkg::SAMPLE_W'(1) : head.sample;
  end

  always_comb begin
    ge        = rem_r >= {1'b0, den_r};
    diff      = ge ? rem_r - {1'b0, den_r} : rem_r;
    rem_shift = {diff[aeg_pkg::DEN_W-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != B_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            rem_r   <= {1'b0, num_pre};
            den_r   <= den_pre;
            gain_r  <= '0;
            cnt_r   <= '0;
            mag_r   <= mag_pre;
            neg_r   <= head.sample[aeg_pkg::SAMPLE_W-1];
            stage_r <= head.stage;
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          rem_r  <= rem_shift;
          gain_r <= {gain_r[aeg_pkg::GAIN_W-2:0], ge};
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(aeg_pkg::GAIN_W - 1)) begin
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          prod_r  <= aeg_pkg::PROD_W'(mag_r) * aeg_pkg::PROD_W'(gain_r);
          state_r <= B_DONE;
        end
        B_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= neg_r ?
                            aeg_pkg::SAMPLE_W'(0) - prod_r[aeg_pkg::PROD_W-2:aeg_pkg::SAMPLE_W] :
                            prod_r[aeg_pkg::PROD_W-2:aeg_pkg::SAMPLE_W];
            out_stage_r  <= stage_r;
            state_r      <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import aeg_pkg::*;

  localparam longint unsigned FULL_SCALE = 65536;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [STAGE_W-1:0]         stage;
  } scaled_t;

  typedef struct packed {
    bit                         is_cfg;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_W-1:0]           val;
    logic                       gw;
    logic                       gl;
    logic signed [SAMPLE_W-1:0] smp;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] want_smp;
    logic [STAGE_W-1:0]         want_stage;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic in_gate_write;
  logic in_gate_level;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic out_valid;
  logic out_ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic [STAGE_W-1:0] out_stage;

  logic [MS_W-1:0] atk_ms, dec_ms, rel_ms;
  logic [SUS_W-1:0] sus_lvl;
  logic [STAGE_W-1:0] env_stage;
  logic [ELAPSED_W-1:0] env_count;

  scaled_t scaled_q[$];
  scaled_t want;
  int errors = 0;
  int burst_left = 0;
  int sent = 0;
  row_t plan [0:28];

  always #10 clk = ~clk;

  adsr_envelope_gain dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_gate_write(in_gate_write),
    .in_gate_level(in_gate_level),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample(out_sample),
    .out_stage(out_stage)
  );

  function automatic longint unsigned samples_of(logic [MS_W-1:0] ms);
    return longint'(ms) * SAMPLES_PER_MS;
  endfunction

  function automatic longint unsigned gain_now();
    longint unsigned c, s, len;
    c = env_count;
    s = sus_lvl;
    case (env_stage)
      ST_ATTACK: begin
        len = samples_of(atk_ms);
        if (len == 0) return FULL_SCALE;
        if (c > len) c = len;
        return (c * FULL_SCALE) / len;
      end
      ST_DECAY: begin
        len = samples_of(dec_ms);
        if (len == 0) return (s * FULL_SCALE) / SUS_FULL;
        if (c > len) c = len;
        return (s * FULL_SCALE * len + (SUS_FULL - s) * FULL_SCALE * (len - c)) /
               (SUS_FULL * len);
      end
      ST_SUSTAIN: return (s * FULL_SCALE) / SUS_FULL;
      ST_RELEASE: begin
        len = samples_of(rel_ms);
        if (len == 0) return 0;
        if (c > len) c = len;
        return (s * FULL_SCALE * (len - c)) / (SUS_FULL * len);
      end
      default: return 0;
    endcase
  endfunction

  function automatic scaled_t scale_and_tick(logic gw, logic gl,
                                             logic signed [SAMPLE_W-1:0] smp);
    scaled_t r;
    longint unsigned mag, prod;
    logic neg;
    if (gw) begin
      env_count = '0;
      env_stage = gl ? ST_ATTACK : ST_RELEASE;
    end
    neg = smp[SAMPLE_W-1];
    mag = neg ? FULL_SCALE - longint'(smp[SAMPLE_W-1:0]) : longint'(smp[SAMPLE_W-1:0]);
    prod = (mag * gain_now()) >> 16;
    r.sample = prod[SAMPLE_W-1:0];
    if (neg) r.sample = -r.sample;
    r.stage = env_stage;
    if (env_count != ELAPSED_MAX) env_count = env_count + 1'b1;
    case (env_stage)
      ST_ATTACK: if (longint'(env_count) > samples_of(atk_ms)) begin
        env_stage = ST_DECAY;
        env_count = '0;
      end
      ST_DECAY: if (longint'(env_count) > samples_of(dec_ms)) env_stage = ST_SUSTAIN;
      ST_RELEASE: if (longint'(env_count) > samples_of(rel_ms)) env_stage = ST_IDLE;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [MS_W-1:0] pick_ms();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return MS_W'($urandom_range(0, 2));
      5: return '0;
      6: return '1;
      7: return MS_W'($urandom);
      8: return MS_W'($urandom_range(3, 8));
      default: return MS_W'(1);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return SAMPLE_W'($urandom_range(0, 3));
      3: return -SAMPLE_W'($urandom_range(1, 3));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic offer(input logic gw, input logic gl,
                       input logic signed [SAMPLE_W-1:0] smp, input bit typed,
                       input logic signed [SAMPLE_W-1:0] want_smp,
                       input logic [STAGE_W-1:0] want_stage);
    int pause;
    scaled_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (pause > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (pause - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_gate_write <= gw;
    in_gate_level <= gl;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    r = scale_and_tick(gw, gl, smp);
    if (typed) begin
      r.sample = want_smp;
      r.stage = want_stage;
    end
    scaled_q.push_back(r);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ATTACK:  atk_ms = val;
      CFG_DECAY:   dec_ms = val;
      CFG_SUSTAIN: sus_lvl = val[SUS_W-1:0];
      CFG_RELEASE: rel_ms = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic noise_item();
    offer($urandom_range(0, 24) == 0, 1'($urandom_range(0, 1)), pick_sample(), 1'b0, '0,
          ST_IDLE);
    sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (scaled_q.size() == 0) begin
        $error("out_sample unexpected transfer: actual %0d, out_stage %0d",
               out_sample, out_stage);
        errors++;
      end else begin
        want = scaled_q.pop_front();
        if (out_sample !== want.sample) begin
          $error("out_sample expected %0d actual %0d", want.sample, out_sample);
          errors++;
        end
        if (out_stage !== want.stage) begin
          $error("out_stage expected %0d actual %0d", want.stage, out_stage);
          errors++;
        end
      end
    end
  end

  initial begin
    int mode, span;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int n_hold, n_tail;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_gate_write = 1'b0;
    in_gate_level = 1'b0;
    in_sample = '0;
    atk_ms = '0;
    dec_ms = '0;
    rel_ms = '0;
    sus_lvl = SUS_W'(SUS_FULL);
    env_stage = ST_IDLE;
    env_count = '0;

    plan = '{
      '{1'b0, CFG_ATTACK, 16'd0, 1'b0, 1'b0, 16'sh7FFF, 1'b1, 16'sd0, ST_IDLE},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b0, 1'b1, 16'sh8000, 1'b1, 16'sd0, ST_IDLE},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b1, 1'b1, 16'sh7FFF, 1'b1, 16'sh7FFF, ST_ATTACK},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b0, 1'b0, 16'sh8000, 1'b1, 16'sh8000, ST_DECAY},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b0, 1'b1, 16'sd12345, 1'b1, 16'sd12345, ST_SUSTAIN},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b1, 1'b0, 16'sh8000, 1'b1, 16'sd0, ST_RELEASE},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b0, 1'b0, 16'sd1, 1'b1, 16'sd0, ST_IDLE},
      '{1'b1, CFG_SUSTAIN, 16'd0, 1'b0, 1'b0, 16'sd0, 1'b0, 16'sd0, ST_IDLE},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b1, 1'b1, 16'shFFFF, 1'b1, 16'shFFFF, ST_ATTACK},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b0, 1'b0, 16'sh7FFF, 1'b1, 16'sd0, ST_DECAY},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b0, 1'b0, 16'sh8000, 1'b1, 16'sd0, ST_SUSTAIN},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b1, 1'b0, 16'sh8000, 1'b1, 16'sd0, ST_RELEASE},
      '{1'b1, CFG_ATTACK, 16'hFFFF, 1'b0, 1'b0, 16'sd0, 1'b0, 16'sd0, ST_IDLE},
      '{1'b1, CFG_DECAY, 16'hFFFF, 1'b0, 1'b0, 16'sd0, 1'b0, 16'sd0, ST_IDLE},
      '{1'b1, CFG_RELEASE, 16'hFFFF, 1'b0, 1'b0, 16'sd0, 1'b0, 16'sd0, ST_IDLE},
      '{1'b1, CFG_SUSTAIN, 16'hFFFF, 1'b0, 1'b0, 16'sd0, 1'b0, 16'sd0, ST_IDLE},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b1, 1'b1, 16'sh7FFF, 1'b1, 16'sd0, ST_ATTACK},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b0, 1'b0, 16'sh8000, 1'b0, 16'sd0, ST_IDLE},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b1, 1'b1, 16'sh8000, 1'b1, 16'sd0, ST_ATTACK},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b1, 1'b0, 16'sh8000, 1'b1, 16'sh8000, ST_RELEASE},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b0, 1'b1, 16'sh7FFF, 1'b0, 16'sd0, ST_IDLE},
      '{1'b1, CFG_ATTACK, 16'd1, 1'b0, 1'b0, 16'sd0, 1'b0, 16'sd0, ST_IDLE},
      '{1'b1, CFG_DECAY, 16'd1, 1'b0, 1'b0, 16'sd0, 1'b0, 16'sd0, ST_IDLE},
      '{1'b1, CFG_SUSTAIN, 16'd128, 1'b0, 1'b0, 16'sd0, 1'b0, 16'sd0, ST_IDLE},
      '{1'b1, CFG_RELEASE, 16'd1, 1'b0, 1'b0, 16'sd0, 1'b0, 16'sd0, ST_IDLE},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b1, 1'b1, 16'sd20000, 1'b0, 16'sd0, ST_IDLE},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b0, 1'b0, -16'sd20000, 1'b0, 16'sd0, ST_IDLE},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b1, 1'b0, 16'sh7FFF, 1'b0, 16'sd0, ST_IDLE},
      '{1'b0, CFG_ATTACK, 16'd0, 1'b0, 1'b1, 16'shFFFF, 1'b0, 16'sd0, ST_IDLE}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        offer(plan[i].gw, plan[i].gl, plan[i].smp, plan[i].typed,
              plan[i].want_smp, plan[i].want_stage);
      end
    end

    while (sent < RANDOM_ITEMS) begin
      drain();
      write_reg(CFG_ATTACK, pick_ms());
      write_reg(CFG_DECAY, pick_ms());
      case ($urandom_range(0, 4))
        0: write_reg(CFG_SUSTAIN, {CFG_W'($urandom)} & 16'hFF00);
        1: write_reg(CFG_SUSTAIN, {CFG_W'($urandom)} | 16'h00FF);
        default: write_reg(CFG_SUSTAIN, CFG_W'($urandom));
      endcase
      write_reg(CFG_RELEASE, pick_ms());
      n_hold = $urandom_range(0, 160);
      n_tail = $urandom_range(0, 130);
      if ($urandom_range(0, 5) != 0) begin
        offer(1'b1, 1'b1, pick_sample(), 1'b0, '0, ST_IDLE);
        sent++;
      end
      repeat (n_hold) noise_item();
      if ($urandom_range(0, 5) != 0) begin
        offer(1'b1, 1'b0, pick_sample(), 1'b0, '0, ST_IDLE);
        sent++;
      end
      repeat (n_tail) noise_item();
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/aeg_pkg.sv
rtl/aeg_queue.sv
rtl/aeg_front.sv
rtl/aeg_back.sv
rtl/adsr_envelope_gain.sv
bench/testbench.sv
